[src/iqsd_pkg.sv]
// package for the iq sample stream decoder
// holds payload structs, format codes and the integer to float32 function
package iqsd_pkg;

    typedef enum logic [1:0] {
        FMT_INT8    = 2'd0,
        FMT_INT16   = 2'd1,
        FMT_FLOAT32 = 2'd2,
        FMT_SPARE   = 2'd3
    } sample_format_t;

    localparam logic [0:0] REG_SAMPLE_FORMAT = 1'b0;
    localparam logic [0:0] REG_BIG_ENDIAN    = 1'b1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [31:0] in_phase_bits;
        logic [31:0] quadrature_bits;
        logic        length_error;
        logic        end_of_buffer;
    } out_item_t;

    // exact float32 of a signed 16-bit value scaled by 2^(exp_top - 142)
    // exp_top is 127 + 15 - scale shift for the msb position 15
    function automatic logic [31:0] int16_to_float(input logic [15:0] w,
                                                   input logic [7:0] exp_top);
        logic        sgn;
        logic [15:0] mag;
        logic [15:0] norm;
        logic [3:0]  lead;
        logic [7:0]  e;
        sgn  = w[15];
        mag  = sgn ? (~w + 16'd1) : w;
        lead = 4'd0;
        for (int i = 0; i < 16; i++)
        begin
            if (mag[i])
            begin
                lead = 4'(i);
            end
        end
        norm = mag << (4'd15 - lead);
        e    = exp_top - 8'(4'd15 - lead);
        if (mag == 16'd0)
        begin
            int16_to_float = 32'd0;
        end
        else
        begin
            int16_to_float = {sgn, e, norm[14:0], 8'd0};
        end
    endfunction

endpackage

[src/iqsd_gather.sv]
// byte gather stage: collects bytes of one i/q pair and registers the group when complete or at a last byte
// depends on iqsd_pkg
module iqsd_gather (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_take,
    input  iqsd_pkg::in_item_t      in_item,
    input  logic [1:0]              fmt,
    input  logic                    flush,
    input  logic                    stage_ready,
    output logic                    stage_valid,
    output logic                    stage_partial,
    output logic                    stage_last,
    output logic [63:0]             stage_bytes
);
    import iqsd_pkg::*;

    logic [55:0] gather_reg;
    logic [2:0]  pos_reg;
    logic [2:0]  group_m1;
    logic        complete;
    logic        valid_reg, partial_reg, last_reg;
    logic [63:0] bytes_reg;
    logic [63:0] merged;

    always_comb
    begin
        case (fmt)
            FMT_INT8:  group_m1 = 3'd1;
            FMT_INT16: group_m1 = 3'd3;
            default:   group_m1 = 3'd7;
        endcase
        complete = (pos_reg == group_m1);
        merged   = {8'd0, gather_reg};
        merged[{pos_reg, 3'b000} +: 8] = in_item.data_byte;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= 3'd0;
            gather_reg <= 56'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (stage_ready)
            begin
                valid_reg <= 1'b0;
            end
            if (flush)
            begin
                pos_reg    <= 3'd0;
                gather_reg <= 56'd0;
            end
            else if (in_take)
            begin
                if (complete || in_item.last_byte)
                begin
                    pos_reg    <= 3'd0;
                    gather_reg <= 56'd0;
                    valid_reg  <= 1'b1;
                end
                else
                begin
                    pos_reg    <= pos_reg + 3'd1;
                    gather_reg <= merged[55:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take && (complete || in_item.last_byte))
        begin
            bytes_reg   <= merged;
            partial_reg <= !complete;
            last_reg    <= in_item.last_byte;
        end
    end

    assign stage_valid   = valid_reg;
    assign stage_partial = partial_reg;
    assign stage_last    = last_reg;
    assign stage_bytes   = bytes_reg;

endmodule

[src/iqsd_convert.sv]
// conversion stage: turns a gathered byte group into two float32 words
// depends on iqsd_pkg
module iqsd_convert (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    stage_valid,
    input  logic                    stage_partial,
    input  logic                    stage_last,
    input  logic [63:0]             stage_bytes,
    input  logic [1:0]              fmt,
    input  logic                    big_endian,
    output logic                    stage_ready,
    output logic                    out_valid,
    input  logic                    out_ready,
    output iqsd_pkg::out_item_t     out_item
);
    import iqsd_pkg::*;

    out_item_t   result_reg, result_next;
    logic        valid_reg;
    logic [15:0] w16_i, w16_q;
    logic [31:0] w32_i, w32_q;

    function automatic logic [31:0] swap32(input logic [31:0] w, input logic be);
        swap32 = be ? {w[7:0], w[15:8], w[23:16], w[31:24]} : w;
    endfunction

    function automatic logic [15:0] swap16(input logic [15:0] w, input logic be);
        swap16 = be ? {w[7:0], w[15:8]} : w;
    endfunction

    assign stage_ready = !valid_reg || out_ready;

    always_comb
    begin
        w16_i = swap16(stage_bytes[15:0], big_endian);
        w16_q = swap16(stage_bytes[31:16], big_endian);
        w32_i = swap32(stage_bytes[31:0], big_endian);
        w32_q = swap32(stage_bytes[63:32], big_endian);
        result_next.length_error  = stage_partial;
        result_next.end_of_buffer = stage_last;
        if (stage_partial)
        begin
            result_next.in_phase_bits   = 32'd0;
            result_next.quadrature_bits = 32'd0;
        end
        else
        begin
            case (fmt)
                FMT_INT8:
                begin
                    result_next.in_phase_bits =
                        int16_to_float({stage_bytes[7:0], 8'd0}, 8'd127);
                    result_next.quadrature_bits =
                        int16_to_float({stage_bytes[15:8], 8'd0}, 8'd127);
                end
                FMT_INT16:
                begin
                    result_next.in_phase_bits   = int16_to_float(w16_i, 8'd127);
                    result_next.quadrature_bits = int16_to_float(w16_q, 8'd127);
                end
                default:
                begin
                    result_next.in_phase_bits   = w32_i;
                    result_next.quadrature_bits = w32_q;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (stage_ready)
        begin
            valid_reg <= stage_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_ready && stage_valid)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = result_reg;

endmodule

[src/iq_sample_stream_decoder.sv]
// iq sample stream decoder top level: configuration registers, gather and convert stages
// depends on iqsd_pkg, iqsd_gather, iqsd_convert
//
// usage:
//   in channel: one raw byte per transfer (in_valid/in_ready), last_byte marks buffer end
//   out channel: one i/q float32 pair per complete byte group (out_valid/out_ready)
//   int8 pairs take 2 bytes, int16 pairs 4, float32 pairs 8; byte order per big_endian
//   a last byte inside a partial pair gives one result with length_error and zero words
//   config: cfg_we, cfg_index, cfg_data; any valid write drops the partial pair
//   path: the closing byte is registered in the gather stage, then in the output stage, before out_valid
//   throughput: one byte per cycle while in_ready is high, set by the gather register taking a byte each cycle
//   two result registers (group stage and output stage) keep input flowing while
//   the receiver stalls; when both are full in_ready drops until out_ready returns
//   reset: format int8, little endian, empty gather and pipeline
module iq_sample_stream_decoder (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  iqsd_pkg::in_item_t      in_data,
    output logic                    out_valid,
    input  logic                    out_ready,
    output iqsd_pkg::out_item_t     out_data,
    input  logic                    cfg_we,
    input  logic [0:0]              cfg_index,
    input  logic [1:0]              cfg_data
);
    import iqsd_pkg::*;

    logic [1:0] fmt_reg;
    logic       be_reg;
    logic       flush;
    logic       stage_valid, stage_ready, stage_partial, stage_last;
    logic [63:0] stage_bytes;

    assign flush    = cfg_we;
    assign in_ready = !stage_valid || stage_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg <= FMT_INT8;
            be_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_SAMPLE_FORMAT)
            begin
                fmt_reg <= cfg_data;
            end
            else
            begin
                be_reg <= cfg_data[0];
            end
        end
    end

    iqsd_gather u_gather (
        .clk(clk), .rst_n(rst_n),
        .in_take(in_valid && in_ready), .in_item(in_data),
        .fmt(fmt_reg), .flush(flush), .stage_ready(stage_ready),
        .stage_valid(stage_valid), .stage_partial(stage_partial),
        .stage_last(stage_last), .stage_bytes(stage_bytes)
    );

    iqsd_convert u_convert (
        .clk(clk), .rst_n(rst_n),
        .stage_valid(stage_valid), .stage_partial(stage_partial),
        .stage_last(stage_last), .stage_bytes(stage_bytes),
        .fmt(fmt_reg), .big_endian(be_reg), .stage_ready(stage_ready),
        .out_valid(out_valid), .out_ready(out_ready), .out_item(out_data)
    );

endmodule

[src/iqsd_checker.sv]
// port checker for the iq sample stream decoder, bound to the top level
// depends on iqsd_pkg
module iqsd_checker (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic                    in_ready,
    input  logic                    out_valid,
    input  logic                    out_ready,
    input  iqsd_pkg::out_item_t     out_data
);
    import iqsd_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.length_error |->
            out_data.end_of_buffer && out_data.in_phase_bits == 32'd0 &&
            out_data.quadrature_bits == 32'd0)
        else $error("length error result malformed");

    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty output");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(in_valid) && !$past(in_valid, 2) && !$past(out_valid) |-> !out_valid)
        else $error("result without input");

endmodule

bind iq_sample_stream_decoder iqsd_checker u_iqsd_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);

[tb/iqsd_checker.sv]
// checker for the iq sample stream decoder: watches the byte, result and register ports
// predicts each i/q pair and compares it with the result transfers; depends on iqsd_pkg
module iqsd_scoreboard (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  iqsd_pkg::in_item_t  in_data,
    input  logic                out_valid,
    input  logic                out_ready,
    input  iqsd_pkg::out_item_t out_data,
    input  logic                cfg_we,
    input  logic [0:0]          cfg_index,
    input  logic [1:0]          cfg_data,
    output int                  errors,
    output int                  pending
);
    import iqsd_pkg::*;

    sample_format_t fmt;
    logic           swap_order;
    logic [7:0]     held [8];
    int             held_count;
    out_item_t      expected_pairs [$];

    // exact float32 of a signed 16-bit value divided by 2^frac
    function automatic logic [31:0] fixed_to_f32(input logic [15:0] v, input int frac);
        logic        sgn;
        logic [15:0] mag;
        logic [31:0] mant;
        int          msb;
        if (v == 16'd0)
        begin
            return 32'd0;
        end
        sgn = v[15];
        mag = sgn ? (16'd0 - v) : v;
        msb = 0;
        for (int i = 0; i < 16; i++)
        begin
            if (mag[i])
            begin
                msb = i;
            end
        end
        mant = 32'(mag) << (23 - msb);
        return {sgn, 8'(127 + msb - frac), mant[22:0]};
    endfunction

    function automatic int pair_bytes(input sample_format_t f);
        case (f)
            FMT_INT8:  return 2;
            FMT_INT16: return 4;
            default:   return 8;
        endcase
    endfunction

    function automatic logic [15:0] half_word(input logic [7:0] b0, input logic [7:0] b1);
        return swap_order ? {b0, b1} : {b1, b0};
    endfunction

    function automatic logic [31:0] full_word(input int base);
        if (swap_order)
        begin
            return {held[base], held[base+1], held[base+2], held[base+3]};
        end
        return {held[base+3], held[base+2], held[base+1], held[base]};
    endfunction

    task automatic take_byte(input in_item_t item);
        out_item_t pair;
        int        group;
        group = pair_bytes(fmt);
        pair  = '0;
        if (held_count + 1 < group)
        begin
            held[held_count] = item.data_byte;
            held_count++;
            if (item.last_byte)
            begin
                pair.length_error  = 1'b1;
                pair.end_of_buffer = 1'b1;
                expected_pairs.push_back(pair);
                held_count = 0;
            end
            return;
        end
        held[group-1] = item.data_byte;
        case (fmt)
            FMT_INT8:
            begin
                pair.in_phase_bits   = fixed_to_f32({{8{held[0][7]}}, held[0]}, 7);
                pair.quadrature_bits = fixed_to_f32({{8{held[1][7]}}, held[1]}, 7);
            end
            FMT_INT16:
            begin
                pair.in_phase_bits   = fixed_to_f32(half_word(held[0], held[1]), 15);
                pair.quadrature_bits = fixed_to_f32(half_word(held[2], held[3]), 15);
            end
            default:
            begin
                pair.in_phase_bits   = full_word(0);
                pair.quadrature_bits = full_word(4);
            end
        endcase
        pair.end_of_buffer = item.last_byte;
        expected_pairs.push_back(pair);
        held_count = 0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            fmt        = FMT_INT8;
            swap_order = 1'b0;
            held_count = 0;
            errors     = 0;
            expected_pairs.delete();
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_pairs.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                    begin
                        $display("unexpected result transfer %h", out_data);
                    end
                end
                else
                begin
                    want = expected_pairs.pop_front();
                    if (want !== out_data)
                    begin
                        errors++;
                        if (errors <= 10)
                        begin
                            $display("mismatch: i %h/%h q %h/%h err %b/%b end %b/%b",
                                     want.in_phase_bits, out_data.in_phase_bits,
                                     want.quadrature_bits, out_data.quadrature_bits,
                                     want.length_error, out_data.length_error,
                                     want.end_of_buffer, out_data.end_of_buffer);
                        end
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                take_byte(in_data);
            end
            if (cfg_we)
            begin
                if (cfg_index == REG_SAMPLE_FORMAT)
                begin
                    fmt = sample_format_t'(cfg_data);
                end
                else
                begin
                    swap_order = cfg_data[0];
                end
                held_count = 0;
            end
        end
        pending = expected_pairs.size();
    end

endmodule

[tb/tb_iq_sample_stream_decoder.sv]
// testbench top for the iq sample stream decoder: clock, reset, byte and register stimulus
// depends on iqsd_pkg, iq_sample_stream_decoder and iqsd_scoreboard
module tb_iq_sample_stream_decoder;
    import iqsd_pkg::*;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    in_item_t  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_data;
    logic      cfg_we = 1'b0;
    logic [0:0] cfg_index = REG_SAMPLE_FORMAT;
    logic [1:0] cfg_data = '0;
    int        errors;
    int        pending;
    logic      calm = 1'b0;
    int        stall_left = 0;
    logic [1:0] fmts [8] = '{FMT_INT8, FMT_INT16, FMT_INT16, FMT_FLOAT32,
                             FMT_FLOAT32, FMT_SPARE, FMT_INT8, FMT_SPARE};
    logic       orders [8] = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0};

    always #2 clk = ~clk;

    iq_sample_stream_decoder dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    iqsd_scoreboard u_scoreboard (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .errors(errors), .pending(pending)
    );

    // receiver stalls in bursts
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 5) == 0)
        begin
            stall_left <= $urandom_range(1, 11) - 1;
            out_ready  <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{data_byte: b, last_byte: last};
        forever
        begin
            @(negedge clk);
            if (in_ready)
            begin
                break;
            end
        end
        @(posedge clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [1:0] val);
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_buffers(input int total, input int group);
        int len;
        int sent;
        sent = 0;
        while (sent < total)
        begin
            len = group * $urandom_range(1, 4);
            if ($urandom_range(0, 5) == 0)
            begin
                len = $urandom_range(1, 3 * group);
            end
            for (int i = 0; i < len; i++)
            begin
                send_byte(8'($urandom), (i == len - 1) && $urandom_range(0, 6) != 0);
            end
            sent += len;
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // int8 extremes, a pair ended by the last byte and a partial pair
        send_byte(8'h00, 1'b0); send_byte(8'h7F, 1'b0);
        send_byte(8'h80, 1'b0); send_byte(8'hFF, 1'b0);
        send_byte(8'h01, 1'b0); send_byte(8'h81, 1'b1);
        send_byte(8'h40, 1'b1);
        write_reg(REG_SAMPLE_FORMAT, FMT_INT16);
        send_byte(8'h00, 1'b0); send_byte(8'h80, 1'b0);
        send_byte(8'hFF, 1'b0); send_byte(8'h7F, 1'b1);
        send_byte(8'h01, 1'b0); send_byte(8'h00, 1'b0); send_byte(8'h12, 1'b1);
        write_reg(REG_BIG_ENDIAN, 2'd1);
        write_reg(REG_SAMPLE_FORMAT, FMT_FLOAT32);
        send_byte(8'h3F, 1'b0); send_byte(8'h80, 1'b0);
        send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0); send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0); send_byte(8'hFF, 1'b1);
        // partial pair dropped by a register write
        send_byte(8'hAA, 1'b0); send_byte(8'h55, 1'b0);
        for (int p = 0; p < 8; p++)
        begin
            write_reg(REG_SAMPLE_FORMAT, fmts[p]);
            write_reg(REG_BIG_ENDIAN, {1'b0, orders[p]});
            if (p == 6)
            begin
                calm = 1'b1;
            end
            random_buffers(66, (fmts[p] == FMT_INT8) ? 2 : (fmts[p] == FMT_INT16) ? 4 : 8);
        end
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (10) @(posedge clk);
        if (errors == 0)
        begin
            $display("[iq_sample_stream_decoder] OK");
        end
        else
        begin
            $display("[iq_sample_stream_decoder] ERROR");
        end
        $finish;
    end

    initial
    begin
        #2000000;
        $display("[iq_sample_stream_decoder] ERROR");
        $finish;
    end

endmodule
